### hw/rtl/vector3_normalize_core_assert.svh
// Assertion macros shared by the normalize core.
`ifndef VECTOR3_NORMALIZE_CORE_ASSERT_SVH
`define VECTOR3_NORMALIZE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define V3N_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("v3n: same-cycle check failed");

// Next-cycle implication, sampled on clk, quiet during reset.
`define V3N_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("v3n: next-cycle check failed");

`endif

### hw/rtl/v3n_pkg.sv
// Types and constants for the vector normalize core.
package v3n_pkg;

	localparam int unsigned COMP_BITS = 32;
	localparam int unsigned ROOT_BITS = 32;
	localparam int unsigned SUM_BITS  = 64;
	localparam int unsigned MINL_BITS = 17;

	typedef struct packed {
		logic signed [COMP_BITS-1:0] vec_x;
		logic signed [COMP_BITS-1:0] vec_y;
		logic signed [COMP_BITS-1:0] vec_z;
	} vec_word_t;

	typedef struct packed {
		logic signed [COMP_BITS-1:0] unit_x;
		logic signed [COMP_BITS-1:0] unit_y;
		logic signed [COMP_BITS-1:0] unit_z;
		logic                        degenerate;
	} unit_word_t;

	typedef struct packed {
		logic [COMP_BITS-1:0] mag_x;
		logic [COMP_BITS-1:0] mag_y;
		logic [COMP_BITS-1:0] mag_z;
		logic [2:0]           neg;
	} mag_t;

	// Square root cell state: running remainder and partial root.
	typedef struct packed {
		logic [SUM_BITS-1:0]  rem;
		logic [ROOT_BITS-1:0] root;
		mag_t                 mag;
	} sq_t;

	// Divider cell state: three partial remainders and quotients.
	typedef struct packed {
		logic [ROOT_BITS-1:0] r_x;
		logic [ROOT_BITS-1:0] r_y;
		logic [ROOT_BITS-1:0] r_z;
		logic [COMP_BITS-1:0] q_x;
		logic [COMP_BITS-1:0] q_y;
		logic [COMP_BITS-1:0] q_z;
		logic [2:0]           feed;
		logic [2:0]           neg;
		logic                 deg;
		logic [ROOT_BITS-1:0] len;
	} div_t;

endpackage

### hw/rtl/vector3_normalize_core.sv
// Top level of the 3D vector normalize pipeline.
// Scales a signed Q16.16 vector to unit length, giving signed Q2.30 components
// truncated toward zero, or the fallback (0, 1.0, 0) with degenerate set when
// the length is zero or below min_length.
// Input channel vec_*: one vector word per accepted cycle (valid high, stall low).
// Output channel unit_*: one result word per input, in order.
// Config channel cfg_*: writes min_length; cfg_ready is always high. Write it
// only while the pipeline is empty.
// Stages: three input stages, 32 square-root cells, one compare stage,
// OUT_FRAC_BITS + 1 divider cells and the output register.
// Throughput: one vector per cycle while the receiver does not stall the output.
// Reset clears every stage valid and sets min_length to 1.
// When the receiver stalls a valid output word, the whole pipeline holds and
// vec_stall rises in the same cycle; it falls as soon as the word is taken.
module vector3_normalize_core
	import v3n_pkg::*;
#(
	parameter int unsigned OUT_FRAC_BITS = 30
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 vec_valid,
	output logic                 vec_stall,
	input  vec_word_t            vec_data,
	output logic                 unit_valid,
	input  logic                 unit_stall,
	output unit_word_t           unit_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [MINL_BITS-1:0] cfg_data
);

	localparam int unsigned DIV_STEPS = OUT_FRAC_BITS + 1;
	localparam logic [COMP_BITS-1:0] UNIT_ONE = COMP_BITS'(1) << OUT_FRAC_BITS;
	localparam logic signed [COMP_BITS-1:0] POS_ONE = UNIT_ONE;
	localparam logic signed [COMP_BITS-1:0] NEG_ONE = -UNIT_ONE;

	logic                 adv;
	logic [MINL_BITS-1:0] min_length_q;

	logic                 v_s1, v_s2, v_s3;
	mag_t                 mag_s1, mag_s2;
	logic [SUM_BITS-1:0]  p_x_s2, p_y_s2, p_z_s2;

	sq_t                  sq_s3;
	sq_t                  sq_c [0:ROOT_BITS];
	logic                 sq_v [0:ROOT_BITS];

	logic                 v_s4;
	div_t                 dv_s4;
	div_t                 dv_c [0:DIV_STEPS];
	logic                 dv_v [0:DIV_STEPS];

	logic                 out_v_q;
	unit_word_t           out_q;
	div_t                 fin;

	assign adv       = !(out_v_q && unit_stall);
	assign vec_stall = !adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q <= MINL_BITS'(1);
		end else if (cfg_valid) begin
			min_length_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_s1    <= vec_valid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= sq_v[ROOT_BITS];
			out_v_q <= dv_v[DIV_STEPS];
		end
	end

	// magnitudes and signs; the most negative input maps to 2^31
	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s1.neg   <= {vec_data.vec_x[COMP_BITS-1], vec_data.vec_y[COMP_BITS-1],
				vec_data.vec_z[COMP_BITS-1]};
			mag_s1.mag_x <= vec_data.vec_x[COMP_BITS-1] ? (~vec_data.vec_x + 1'b1) : vec_data.vec_x;
			mag_s1.mag_y <= vec_data.vec_y[COMP_BITS-1] ? (~vec_data.vec_y + 1'b1) : vec_data.vec_y;
			mag_s1.mag_z <= vec_data.vec_z[COMP_BITS-1] ? (~vec_data.vec_z + 1'b1) : vec_data.vec_z;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s2 <= mag_s1;
			p_x_s2 <= mag_s1.mag_x * mag_s1.mag_x;
			p_y_s2 <= mag_s1.mag_y * mag_s1.mag_y;
			p_z_s2 <= mag_s1.mag_z * mag_s1.mag_z;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s3.rem  <= p_x_s2 + p_y_s2 + p_z_s2;
			sq_s3.root <= '0;
			sq_s3.mag  <= mag_s2;
		end
	end
	assign sq_c[0] = sq_s3;
	assign sq_v[0] = v_s3;

	for (genvar k = 0; k < ROOT_BITS; k++) begin : g_sqrt
		v3n_sqrt_cell #(
			.STEP(ROOT_BITS - 1 - k)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (adv),
			.prev_valid (sq_v[k]),
			.prev_data  (sq_c[k]),
			.valid      (sq_v[k+1]),
			.data       (sq_c[k+1])
		);
	end

	// seed dividers: top bits of |v| << OUT_FRAC_BITS never exceed len
	always_ff @(posedge clk) begin
		if (adv) begin
			dv_s4.len  <= sq_c[ROOT_BITS].root;
			dv_s4.deg  <= (sq_c[ROOT_BITS].root == '0) ||
				(sq_c[ROOT_BITS].root < ROOT_BITS'(min_length_q));
			dv_s4.neg  <= sq_c[ROOT_BITS].mag.neg;
			dv_s4.r_x  <= {1'b0, sq_c[ROOT_BITS].mag.mag_x[COMP_BITS-1:1]};
			dv_s4.r_y  <= {1'b0, sq_c[ROOT_BITS].mag.mag_y[COMP_BITS-1:1]};
			dv_s4.r_z  <= {1'b0, sq_c[ROOT_BITS].mag.mag_z[COMP_BITS-1:1]};
			dv_s4.feed <= {sq_c[ROOT_BITS].mag.mag_x[0], sq_c[ROOT_BITS].mag.mag_y[0],
				sq_c[ROOT_BITS].mag.mag_z[0]};
			dv_s4.q_x  <= '0;
			dv_s4.q_y  <= '0;
			dv_s4.q_z  <= '0;
		end
	end
	assign dv_c[0] = dv_s4;
	assign dv_v[0] = v_s4;

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		v3n_div_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (adv),
			.prev_valid (dv_v[k]),
			.prev_data  (dv_c[k]),
			.valid      (dv_v[k+1]),
			.data       (dv_c[k+1])
		);
	end

	assign fin = dv_c[DIV_STEPS];

	always_ff @(posedge clk) begin
		if (adv) begin
			if (fin.deg) begin
				out_q.unit_x     <= '0;
				out_q.unit_y     <= UNIT_ONE;
				out_q.unit_z     <= '0;
				out_q.degenerate <= 1'b1;
			end else begin
				out_q.unit_x     <= fin.neg[2] ? -fin.q_x : fin.q_x;
				out_q.unit_y     <= fin.neg[1] ? -fin.q_y : fin.q_y;
				out_q.unit_z     <= fin.neg[0] ? -fin.q_z : fin.q_z;
				out_q.degenerate <= 1'b0;
			end
		end
	end

	assign unit_valid = out_v_q;
	assign unit_data  = out_q;

	logic fallback_ok;
	logic range_ok;

	assign fallback_ok = (unit_data.unit_x == '0) && (unit_data.unit_z == '0) &&
		(unit_data.unit_y == POS_ONE);
	assign range_ok = (unit_data.unit_x <= POS_ONE) && (unit_data.unit_x >= NEG_ONE) &&
		(unit_data.unit_z <= POS_ONE) && (unit_data.unit_z >= NEG_ONE);

	`include "vector3_normalize_core_assert.svh"

	`V3N_ASSERT_IMP(a_fallback, unit_valid && unit_data.degenerate, fallback_ok)
	`V3N_ASSERT_IMP(a_range, unit_valid && !unit_data.degenerate, range_ok)
	`V3N_ASSERT_IMP(a_stall_cause, vec_stall, unit_valid && unit_stall)
	`V3N_ASSERT_NEXT(a_hold_last, vec_stall, unit_valid)

endmodule

### hw/rtl/v3n_sqrt_cell.sv
// One bit of the integer square root: tries bit STEP of the root.
module v3n_sqrt_cell
	import v3n_pkg::*;
#(
	parameter int unsigned STEP = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic prev_valid,
	input  sq_t  prev_data,
	output logic valid,
	output sq_t  data
);

	localparam int unsigned TW = SUM_BITS + 2;

	logic [TW-1:0] trial;
	logic          take;
	sq_t           next;
	logic          valid_q;
	sq_t           data_q;

	// trial = (2*root + 2^STEP) * 2^STEP, root holds only bits above STEP
	always_comb begin
		trial = (TW'(prev_data.root) << (STEP + 1)) | (TW'(1) << (2 * STEP));
		take  = {2'b00, prev_data.rem} >= trial;
		next  = prev_data;
		if (take) begin
			next.rem  = prev_data.rem - trial[SUM_BITS-1:0];
			next.root = prev_data.root | (ROOT_BITS'(1) << STEP);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= next;
		end
	end

	assign valid = valid_q;
	assign data  = data_q;

endmodule

### hw/rtl/v3n_div_cell.sv
// One quotient bit of the three restoring dividers.
module v3n_div_cell
	import v3n_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic prev_valid,
	input  div_t prev_data,
	output logic valid,
	output div_t data
);

	logic [ROOT_BITS:0] w_x, w_y, w_z;
	logic               ge_x, ge_y, ge_z;
	div_t               next;
	logic               valid_q;
	div_t               data_q;

	always_comb begin
		w_x  = {prev_data.r_x, prev_data.feed[2]};
		w_y  = {prev_data.r_y, prev_data.feed[1]};
		w_z  = {prev_data.r_z, prev_data.feed[0]};
		ge_x = w_x >= {1'b0, prev_data.len};
		ge_y = w_y >= {1'b0, prev_data.len};
		ge_z = w_z >= {1'b0, prev_data.len};
		next      = prev_data;
		next.feed = 3'b000;
		next.r_x  = ge_x ? ROOT_BITS'(w_x - {1'b0, prev_data.len}) : w_x[ROOT_BITS-1:0];
		next.r_y  = ge_y ? ROOT_BITS'(w_y - {1'b0, prev_data.len}) : w_y[ROOT_BITS-1:0];
		next.r_z  = ge_z ? ROOT_BITS'(w_z - {1'b0, prev_data.len}) : w_z[ROOT_BITS-1:0];
		next.q_x  = {prev_data.q_x[COMP_BITS-2:0], ge_x};
		next.q_y  = {prev_data.q_y[COMP_BITS-2:0], ge_y};
		next.q_z  = {prev_data.q_z[COMP_BITS-2:0], ge_z};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= next;
		end
	end

	assign valid = valid_q;
	assign data  = data_q;

endmodule

### tb/tb.sv
// Testbench for the vector normalize core: queued driver, monitor, inline predictor.
`timescale 1ns / 1ps
module tb;
	import v3n_pkg::*;

	localparam int OFB = 30;
	localparam int LATENCY = OFB + 38;
	localparam longint LIMIT = 400000;

	logic clk = 0;
	logic arst_n = 0;
	logic vec_valid = 0;
	logic vec_stall;
	vec_word_t vec_data = '0;
	logic unit_valid;
	logic unit_stall = 0;
	unit_word_t unit_data;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [MINL_BITS-1:0] cfg_data = '0;

	vector3_normalize_core #(.OUT_FRAC_BITS(OFB)) uut (
		.clk(clk), .arst_n(arst_n),
		.vec_valid(vec_valid), .vec_stall(vec_stall), .vec_data(vec_data),
		.unit_valid(unit_valid), .unit_stall(unit_stall), .unit_data(unit_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	vec_word_t pending_vecs[$];
	unit_word_t expected_units[$];
	logic [MINL_BITS-1:0] min_len = 1;
	int errors = 0;
	int checked = 0;
	int degen_seen = 0;
	longint cycles = 0;
	int send_gap = 0;
	int recv_gap = 0;
	int hold_off = 0;
	logic cfg_pending = 0;
	logic [MINL_BITS-1:0] cfg_value = '0;

	function automatic logic [63:0] root64(logic [63:0] s);
		logic [63:0] rem, root, bitv;
		rem = s;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > rem) bitv >>= 2;
		while (bitv != 0) begin
			if (rem >= root + bitv) begin
				rem -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic logic [31:0] scale_comp(logic [31:0] v, logic [63:0] len);
		logic [63:0] mag, q;
		mag = v[31] ? {32'd0, -v} : {32'd0, v};
		q = (mag << OFB) / len;
		if (v[31]) q = -q;
		return q[31:0];
	endfunction

	function automatic unit_word_t normalize_vec(vec_word_t w);
		unit_word_t r;
		logic [63:0] mx, my, mz, len;
		mx = w.vec_x[31] ? {32'd0, -w.vec_x} : {32'd0, w.vec_x};
		my = w.vec_y[31] ? {32'd0, -w.vec_y} : {32'd0, w.vec_y};
		mz = w.vec_z[31] ? {32'd0, -w.vec_z} : {32'd0, w.vec_z};
		len = root64(mx * mx + my * my + mz * mz);
		if (len == 0 || len < {47'd0, min_len}) begin
			r.unit_x = 0;
			r.unit_y = 32'sd1 << OFB;
			r.unit_z = 0;
			r.degenerate = 1;
		end else begin
			r.unit_x = scale_comp(w.vec_x, len);
			r.unit_y = scale_comp(w.vec_y, len);
			r.unit_z = scale_comp(w.vec_z, len);
			r.degenerate = 0;
		end
		return r;
	endfunction

	function automatic logic [31:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 255) - 128;
			2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
			3: return $urandom_range(0, 1) ? 32'h0 : 32'hffff_ffff;
			4: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
			default: return $urandom >> $urandom_range(0, 31);
		endcase
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// Driver: hold the word while stalled, draw a gap per word.
	always @(posedge clk) begin
		if (arst_n) begin
			if (vec_valid && !vec_stall) begin
				expected_units.push_back(normalize_vec(vec_data));
			end
			if (!vec_valid || !vec_stall) begin
				if (send_gap > 0 || pending_vecs.size() == 0) begin
					vec_valid <= 0;
					if (send_gap > 0) send_gap <= send_gap - 1;
				end else begin
					vec_data <= pending_vecs.pop_front();
					vec_valid <= 1;
					send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
				end
			end
		end
		if (cfg_valid && cfg_ready) begin
			min_len <= cfg_data;
			cfg_valid <= 0;
		end else if (cfg_pending && !cfg_valid) begin
			cfg_data <= cfg_value;
			cfg_valid <= 1;
		end
	end

	// Monitor: check the word, then draw the next stall.
	always @(posedge clk) begin
		if (arst_n) begin
			if (unit_valid && !unit_stall) begin
				if (expected_units.size() == 0) begin
					$error("unexpected result word %h", unit_data);
					errors++;
				end else begin
					unit_word_t e;
					e = expected_units.pop_front();
					checked++;
					if (e.degenerate) degen_seen++;
					if (unit_data.unit_x !== e.unit_x) begin
						$error("unit_x exp %h got %h", e.unit_x, unit_data.unit_x);
						errors++;
					end
					if (unit_data.unit_y !== e.unit_y) begin
						$error("unit_y exp %h got %h", e.unit_y, unit_data.unit_y);
						errors++;
					end
					if (unit_data.unit_z !== e.unit_z) begin
						$error("unit_z exp %h got %h", e.unit_z, unit_data.unit_z);
						errors++;
					end
					if (unit_data.degenerate !== e.degenerate) begin
						$error("degenerate exp %b got %b", e.degenerate,
							unit_data.degenerate);
						errors++;
					end
				end
			end
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				unit_stall <= 1;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				unit_stall <= 1;
			end else begin
				unit_stall <= 0;
				if (unit_valid && ($urandom_range(0, 3) == 0))
					recv_gap <= $urandom_range(0, 13);
			end
		end
	end

	task automatic wait_drain();
		while (pending_vecs.size() != 0 || vec_valid || expected_units.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic write_min_len(logic [MINL_BITS-1:0] v);
		cfg_value = v;
		cfg_pending = 1;
		@(posedge clk);
		while (!(cfg_valid && cfg_ready)) @(posedge clk);
		cfg_pending = 0;
		@(posedge clk);
	endtask

	task automatic queue_random(int n);
		vec_word_t w;
		repeat (n) begin
			w.vec_x = rand_comp();
			w.vec_y = rand_comp();
			w.vec_z = rand_comp();
			pending_vecs.push_back(w);
		end
	endtask

	initial begin
		logic [MINL_BITS-1:0] settings[6];
		vec_word_t w;
		settings = '{17'd0, 17'd65536, 17'h1ffff, 17'd256, 17'd1, 17'd40000};
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: extremes and zero length at the reset minimum.
		w = '{32'sh0, 32'sh0, 32'sh0}; pending_vecs.push_back(w);
		w = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000}; pending_vecs.push_back(w);
		w = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff}; pending_vecs.push_back(w);
		w = '{32'sh8000_0000, 32'sh0, 32'sh0}; pending_vecs.push_back(w);
		w = '{32'sh0, 32'sh7fff_ffff, 32'sh0}; pending_vecs.push_back(w);
		w = '{32'sh0, 32'sh0, -32'sh1}; pending_vecs.push_back(w);
		w = '{32'sh1, 32'sh0, 32'sh0}; pending_vecs.push_back(w);
		w = '{32'sh1_0000, -32'sh1_0000, 32'sh1_0000}; pending_vecs.push_back(w);
		w = '{-32'sh3_0000, 32'sh4_0000, 32'sh0}; pending_vecs.push_back(w);
		w = '{32'shffff_ffff, 32'shffff_ffff, 32'shffff_ffff}; pending_vecs.push_back(w);
		wait_drain();

		// Zero minimum: zero length must still fall back.
		write_min_len(17'd0);
		w = '{32'sh0, 32'sh0, 32'sh0}; pending_vecs.push_back(w);
		w = '{32'sh1, 32'sh1, 32'sh1}; pending_vecs.push_back(w);
		wait_drain();

		foreach (settings[i]) begin
			write_min_len(settings[i]);
			queue_random(300);
			if (i == 2) begin
				// Long receiver hold-off so the pipeline fills and stalls input.
				@(posedge clk);
				hold_off <= 200;
			end
			wait_drain();
		end
		write_min_len(17'd1);
		queue_random(100);
		wait_drain();

		$display("tb: %0d result words checked, %0d degenerate, %0d errors",
			checked, degen_seen, errors);
		$display("tb: covered min_length from 0 to 131071, input and output stalls");
		if (errors == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end
endmodule
